@@ hw/rtl/boxds_pkg.sv @@
// shared types, constants and channel arithmetic for the 2x2 box downsampler
package boxds_pkg;

	localparam int CHAN_N  = 4;
	localparam int CHAN_W  = 8;
	localparam int SUM_W   = CHAN_W + 1;
	localparam int PIX_W   = CHAN_N * CHAN_W;
	localparam int LINE_W  = CHAN_N * SUM_W;
	localparam int COL_W   = 13;
	localparam int ROW_W   = 16;
	localparam int PAIR_W  = 14;
	localparam int CFG_W   = 16;

	typedef enum logic {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} cfg_reg_t;

	// per-transaction line store request from the counter logic
	typedef struct packed {
		logic wr;
		logic rd;
		logic frame_end;
	} line_req_t;

	// column-pair sums, channel 0 in the low bits
	function automatic logic [LINE_W-1:0] pair_sums(input logic [PIX_W-1:0] held,
			input logic [PIX_W-1:0] pix);
		logic [LINE_W-1:0] s;
		s = '0;
		for (int c = 0; c < CHAN_N; c++) begin
			s[c*SUM_W +: SUM_W] = {1'b0, held[c*CHAN_W +: CHAN_W]} +
				{1'b0, pix[c*CHAN_W +: CHAN_W]};
		end
		return s;
	endfunction

	// add the two row sums and drop the two low bits
	function automatic logic [PIX_W-1:0] block_avg(input logic [LINE_W-1:0] prev,
			input logic [LINE_W-1:0] cur);
		logic [PIX_W-1:0] r;
		logic [SUM_W:0] t;
		r = '0;
		for (int c = 0; c < CHAN_N; c++) begin
			t = {1'b0, prev[c*SUM_W +: SUM_W]} + {1'b0, cur[c*SUM_W +: SUM_W]};
			r[c*CHAN_W +: CHAN_W] = t[SUM_W:2];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/box_downsample_2x2_argb.sv @@
// 2x2 box downsampler for four-channel 8-bit pixels, stream in and stream out
// Takes one source pixel per clock in raster order and emits one pixel per 2x2
// block, each channel the truncated mean of its four samples; the last output of a
// frame carries tlast. Even rows leave column-pair sums in a line store of
// MAX_WIDTH/2 entries (one write and one registered read per clock); on odd rows
// the second pixel of each pair reads its entry, and the result passes through the
// stage 1 register into the output register. Sustained rate is one pixel per clock
// with no stall other than output back-pressure. Source width and height are set
// through the configuration channel (index 0: width, index 1: height); the user must
// set them only while no frame is in flight; the block does not enforce it. A zero
// size discards pixels; odd last column/row and columns past MAX_WIDTH are dropped.
module box_downsample_2x2_argb import boxds_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [PIX_W-1:0]    s_axis_tdata,   // chan_0, chan_1, chan_2, chan_3
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [PIX_W-1:0]    m_axis_tdata,   // avg_0, avg_1, avg_2, avg_3
	output logic                m_axis_tlast
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	line_req_t         req;
	logic [ADDR_W-1:0] addr;
	logic [LINE_W-1:0] sums;
	logic [LINE_W-1:0] prev_sums;
	logic              accept;
	logic              out_free;

	logic              valid_s1;
	logic              last_s1;
	logic [LINE_W-1:0] sums_s1;
	logic              out_valid_q;
	logic              out_last_q;
	logic [PIX_W-1:0]  out_data_q;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	boxds_ctrl #(
		.LINE_DEPTH (LINE_DEPTH),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_sel   (cfg_reg_t'(cfg_index)),
		.cfg_wdata (cfg_data),
		.accept    (accept),
		.pixel     (s_axis_tdata),
		.req       (req),
		.addr      (addr),
		.sums      (sums)
	);

	// an entry is written on an even row and read a full row later, so no forwarding
	boxds_line #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_line (
		.clk     (clk),
		.wr_en   (req.wr),
		.rd_en   (req.rd),
		.addr    (addr),
		.wr_data (sums),
		.rd_data (prev_sums)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.rd) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			sums_s1 <= sums;
			last_s1 <= req.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_data_q <= block_avg(prev_sums, sums_s1);
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_no_wr_rd_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr && req.rd))
		else $error("line store written and read by the same transaction");

	a_read_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd |=> valid_s1)
		else $error("line store read without a stage 1 result");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(sums_s1) && $stable(prev_sums)))
		else $error("stage 1 operands lost under back-pressure");

	a_s1_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |=> out_valid_q)
		else $error("stage 1 result not moved into the output register");

endmodule

@@ hw/rtl/boxds_line.sv @@
// line store of column-pair sums: one write and one registered read per cycle
module boxds_line import boxds_pkg::*; #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] addr,
	input  logic [LINE_W-1:0] wr_data,
	output logic [LINE_W-1:0] rd_data
);

	logic [LINE_W-1:0] mem_q [DEPTH];
	logic [LINE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
	end

	// read data holds until the next read so a stalled result keeps its operand
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/boxds_ctrl.sv @@
// size registers, column and row counters, held pixel and line store requests
module boxds_ctrl import boxds_pkg::*; #(
	parameter int LINE_DEPTH = 2048,
	parameter int ADDR_W     = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_reg_t          cfg_sel,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              accept,
	input  logic [PIX_W-1:0]  pixel,
	output line_req_t         req,
	output logic [ADDR_W-1:0] addr,
	output logic [LINE_W-1:0] sums
);

	localparam logic [PAIR_W-1:0] DEPTH_P = PAIR_W'(LINE_DEPTH);

	logic [COL_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PIX_W-1:0]  held_q;

	logic              active;
	logic [PAIR_W-1:0] pair;
	logic [PAIR_W-1:0] half_width;
	logic [PAIR_W-1:0] usable;
	logic [ROW_W-1:0]  used_rows;
	logic              in_range;
	logic [PAIR_W-1:0] col_inc;
	logic [ROW_W:0]    row_inc;
	logic              col_wrap;
	logic              row_wrap;

	always_comb begin
		active     = (width_q != '0) && (height_q != '0);
		pair       = {{(PAIR_W-COL_W+1){1'b0}}, col_q[COL_W-1:1]};
		half_width = {{(PAIR_W-COL_W+1){1'b0}}, width_q[COL_W-1:1]};
		usable     = (half_width > DEPTH_P) ? DEPTH_P : half_width;
		used_rows  = {height_q[ROW_W-1:1], 1'b0};
		in_range   = active && (pair < usable) && (row_q < used_rows);
		col_inc    = {{(PAIR_W-COL_W){1'b0}}, col_q} + PAIR_W'(1);
		row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
		col_wrap   = col_inc >= {{(PAIR_W-COL_W){1'b0}}, width_q};
		row_wrap   = row_inc >= {1'b0, height_q};

		req.wr        = accept && in_range && col_q[0] && !row_q[0];
		req.rd        = accept && in_range && col_q[0] && row_q[0];
		req.frame_end = (row_q == used_rows - ROW_W'(1)) && (pair == usable - PAIR_W'(1));
		addr          = pair[ADDR_W-1:0];
		sums          = pair_sums(held_q, pixel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				REG_SRC_WIDTH:  width_q  <= cfg_wdata[COL_W-1:0];
				REG_SRC_HEIGHT: height_q <= cfg_wdata[ROW_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept && active) begin
			if (in_range && !col_q[0]) begin
				held_q <= pixel;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

endmodule
